FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: src/prt_pkg.sv
// ---------------------------------------------------------------------------
// prt_pkg
// types, constants and microcode rom of the page region tracker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prt_pkg;

   localparam int ENTRIES    = 1024;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 31;
   localparam int COUNT_W    = 12;
   localparam int SLOT_W     = 10;
   localparam int STAT_W     = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   typedef logic [ADDR_W-1:0] entry_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef enum logic {
      CMD_ALLOC  = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_INVALID   = 2'd1,
      STAT_EXHAUSTED = 2'd2,
      STAT_NO_REGION = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AWRITE,
      ST_RSETUP,
      ST_SCAN,
      ST_RESOLVE,
      ST_AFOUND,
      ST_AEXH,
      ST_RHIT,
      ST_ERR1,
      ST_ERR2,
      ST_ERR3,
      ST_RESP
   } step_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LATCH,
      OP_AWRITE,
      OP_RSETUP,
      OP_SCAN,
      OP_AFOUND,
      OP_AEXH,
      OP_RHIT,
      OP_ERROR,
      OP_RESP
   } op_type;

   typedef enum logic [1:0] {
      J_GOTO,
      J_WAIT,
      J_DISPATCH
   } jump_type;

   typedef enum logic [1:0] {
      C_NONE,
      C_CLR_DONE,
      C_SCAN_END,
      C_RSP_TAKEN
   } cond_type;

   typedef enum logic {
      DS_REQ,
      DS_SCAN
   } disp_type;

   typedef struct packed {
      op_type     op;
      jump_type   jump;
      cond_type   cond;
      disp_type   disp;
      status_type stat;
      step_type   target;
   } ctrl_word_type;

   function automatic ctrl_word_type rom_read(step_type s);
      ctrl_word_type w;
      w = '{op: OP_NONE, jump: J_GOTO, cond: C_NONE, disp: DS_REQ,
            stat: STAT_OK, target: ST_IDLE};
      unique case (s)
         ST_CLEAR: begin
            w.op = OP_CLEAR;   w.jump = J_WAIT; w.cond = C_CLR_DONE; w.target = ST_IDLE;
         end
         ST_IDLE: begin
            w.op = OP_LATCH;   w.jump = J_DISPATCH; w.disp = DS_REQ;
         end
         ST_AWRITE: begin
            w.op = OP_AWRITE;  w.target = ST_SCAN;
         end
         ST_RSETUP: begin
            w.op = OP_RSETUP;  w.target = ST_SCAN;
         end
         ST_SCAN: begin
            w.op = OP_SCAN;    w.jump = J_WAIT; w.cond = C_SCAN_END; w.target = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            w.jump = J_DISPATCH; w.disp = DS_SCAN;
         end
         ST_AFOUND: begin
            w.op = OP_AFOUND;  w.target = ST_RESP;
         end
         ST_AEXH: begin
            w.op = OP_AEXH;    w.target = ST_RESP;
         end
         ST_RHIT: begin
            w.op = OP_RHIT;    w.target = ST_RESP;
         end
         ST_ERR1: begin
            w.op = OP_ERROR;   w.stat = STAT_INVALID;   w.target = ST_RESP;
         end
         ST_ERR2: begin
            w.op = OP_ERROR;   w.stat = STAT_EXHAUSTED; w.target = ST_RESP;
         end
         ST_ERR3: begin
            w.op = OP_ERROR;   w.stat = STAT_NO_REGION; w.target = ST_RESP;
         end
         ST_RESP: begin
            w.op = OP_RESP;    w.jump = J_WAIT; w.cond = C_RSP_TAKEN; w.target = ST_IDLE;
         end
         default: begin
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic idx_type idx_inc(idx_type i);
      return (i == IDX_W'(ENTRIES - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic idx_type idx_dec(idx_type i);
      return (i == '0) ? IDX_W'(ENTRIES - 1) : i - 1'b1;
   endfunction

endpackage

FILE: src/page_region_tracker_top.sv
// ---------------------------------------------------------------------------
// page_region_tracker_top
// table of allocated page regions driven by a microcoded sequencer
// throughput: one request at a time; the table walk reads one slot per cycle
//   through the single read port of the region memory
// reset: a clearing pass zeroes the table, req_tready is low
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module page_region_tracker_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // base_address [31:0], length_bytes [62:32], zero [63]
   input  logic [prt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd [0]
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [1:0], page_count [13:2], slot_index [23:14]
   output logic [prt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int IDX_W = prt_pkg::IDX_W;
   localparam int PS    = prt_pkg::PAGE_SHIFT;
   localparam int CW    = prt_pkg::COUNT_W;
   localparam int AW    = prt_pkg::ADDR_W;

   prt_pkg::entry_type region_mem [prt_pkg::ENTRIES];

   prt_pkg::step_type      step_ff, step_in;
   prt_pkg::ctrl_word_type cw;

   prt_pkg::cmd_type              cmd_ff, cmd_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [prt_pkg::LEN_W-1:0]     len_ff, len_in;
   prt_pkg::idx_type              addr_ff, addr_in;
   prt_pkg::idx_type              stop_ff, stop_in;
   logic                          done_ff, done_in;
   logic                          qvld_ff, qvld_in;
   prt_pkg::idx_type              qidx_ff, qidx_in;
   prt_pkg::entry_type            q_ff;
   prt_pkg::idx_type              nf_ff, nf_in;
   logic                          exh_ff, exh_in;
   prt_pkg::status_type           stat_ff, stat_in;
   logic [CW-1:0]                 pages_ff, pages_in;
   logic [prt_pkg::SLOT_W-1:0]    slot_ff, slot_in;

   logic                          wr_en, rd_en;
   prt_pkg::idx_type              wr_addr;
   prt_pkg::entry_type            wr_data;

   logic [AW-1:0]                 req_base;
   logic [prt_pkg::LEN_W-1:0]     req_len;
   prt_pkg::cmd_type              req_cmd;
   logic                          req_acc, hit, miss, cond_true;
   prt_pkg::step_type             req_target, scan_target;

   assign cw       = prt_pkg::rom_read(step_ff);
   assign req_base = req_tdata[AW-1:0];
   assign req_len  = req_tdata[AW +: prt_pkg::LEN_W];
   assign req_cmd  = prt_pkg::cmd_type'(req_tuser[0]);
   assign req_acc  = req_tvalid && req_tready;

   assign req_tready = (cw.op == prt_pkg::OP_LATCH);
   assign rsp_tvalid = (cw.op == prt_pkg::OP_RESP);
   assign rsp_tdata  = {slot_ff, pages_ff, stat_ff};

   // entry match for the current walk
   assign hit  = qvld_ff && ((cmd_ff == prt_pkg::CMD_ALLOC) ? (q_ff == '0)
                             : (q_ff[AW-1:PS] == base_ff[AW-1:PS]));
   assign miss = done_ff && !qvld_ff;

   always_comb begin
      unique case (cw.cond)
         prt_pkg::C_CLR_DONE:  cond_true = (addr_ff == IDX_W'(prt_pkg::ENTRIES - 1));
         prt_pkg::C_SCAN_END:  cond_true = hit || miss;
         prt_pkg::C_RSP_TAKEN: cond_true = rsp_tready;
         default:              cond_true = 1'b0;
      endcase
   end

   always_comb begin
      priority if (!req_acc) begin
         req_target = prt_pkg::ST_IDLE;
      end else if (req_base[PS-1:0] != '0) begin
         req_target = prt_pkg::ST_ERR1;
      end else if (req_cmd == prt_pkg::CMD_REMOVE) begin
         req_target = prt_pkg::ST_RSETUP;
      end else if ((req_len[PS-1:0] != '0) || (req_len[prt_pkg::LEN_W-1:PS+CW] != '0)) begin
         req_target = prt_pkg::ST_ERR1;
      end else if (exh_ff) begin
         req_target = prt_pkg::ST_ERR2;
      end else begin
         req_target = prt_pkg::ST_AWRITE;
      end
   end

   always_comb begin
      priority if (cmd_ff == prt_pkg::CMD_ALLOC) begin
         scan_target = hit ? prt_pkg::ST_AFOUND : prt_pkg::ST_AEXH;
      end else if (hit && (q_ff[CW-1:0] != '0)) begin
         scan_target = prt_pkg::ST_RHIT;
      end else begin
         scan_target = prt_pkg::ST_ERR3;
      end
   end

   always_comb begin
      unique case (cw.jump)
         prt_pkg::J_GOTO:     step_in = cw.target;
         prt_pkg::J_WAIT:     step_in = cond_true ? cw.target : step_ff;
         prt_pkg::J_DISPATCH: step_in = (cw.disp == prt_pkg::DS_REQ) ? req_target : scan_target;
         default:             step_in = prt_pkg::ST_IDLE;
      endcase
   end

   // datapath driven by the control word
   always_comb begin
      cmd_in   = cmd_ff;
      base_in  = base_ff;
      len_in   = len_ff;
      addr_in  = addr_ff;
      stop_in  = stop_ff;
      done_in  = done_ff;
      qvld_in  = qvld_ff;
      qidx_in  = qidx_ff;
      nf_in    = nf_ff;
      exh_in   = exh_ff;
      stat_in  = stat_ff;
      pages_in = pages_ff;
      slot_in  = slot_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = '0;
      unique case (cw.op)
         prt_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = prt_pkg::idx_inc(addr_ff);
         end
         prt_pkg::OP_LATCH: begin
            if (req_acc) begin
               cmd_in  = req_cmd;
               base_in = req_base;
               len_in  = req_len;
            end
         end
         prt_pkg::OP_AWRITE: begin
            wr_en    = 1'b1;
            wr_addr  = nf_ff;
            wr_data  = {base_ff[AW-1:PS], len_ff[PS +: CW]};
            stat_in  = prt_pkg::STAT_OK;
            pages_in = len_ff[PS +: CW];
            slot_in  = prt_pkg::SLOT_W'(nf_ff);
            addr_in  = prt_pkg::idx_inc(nf_ff);
            stop_in  = prt_pkg::idx_dec(nf_ff);
            done_in  = 1'b0;
            qvld_in  = 1'b0;
         end
         prt_pkg::OP_RSETUP: begin
            addr_in = '0;
            stop_in = IDX_W'(prt_pkg::ENTRIES - 1);
            done_in = 1'b0;
            qvld_in = 1'b0;
         end
         prt_pkg::OP_SCAN: begin
            if (!hit) begin
               if (!done_ff) begin
                  rd_en   = 1'b1;
                  qvld_in = 1'b1;
                  qidx_in = addr_ff;
                  addr_in = prt_pkg::idx_inc(addr_ff);
                  done_in = (addr_ff == stop_ff);
               end else begin
                  qvld_in = 1'b0;
               end
            end
         end
         prt_pkg::OP_AFOUND: begin
            nf_in = qidx_ff;
         end
         prt_pkg::OP_AEXH: begin
            exh_in = 1'b1;
         end
         prt_pkg::OP_RHIT: begin
            wr_en    = 1'b1;
            wr_addr  = qidx_ff;
            stat_in  = prt_pkg::STAT_OK;
            pages_in = q_ff[CW-1:0];
            slot_in  = prt_pkg::SLOT_W'(qidx_ff);
            if (exh_ff) begin
               exh_in = 1'b0;
               nf_in  = qidx_ff;
            end
         end
         prt_pkg::OP_ERROR: begin
            stat_in  = cw.stat;
            pages_in = '0;
            slot_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         region_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= region_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= prt_pkg::ST_CLEAR;
         addr_ff <= '0;
         done_ff <= 1'b0;
         qvld_ff <= 1'b0;
         nf_ff   <= '0;
         exh_ff  <= 1'b0;
      end else begin
         step_ff <= step_in;
         addr_ff <= addr_in;
         done_ff <= done_in;
         qvld_ff <= qvld_in;
         nf_ff   <= nf_in;
         exh_ff  <= exh_in;
      end
      cmd_ff   <= cmd_in;
      base_ff  <= base_in;
      len_ff   <= len_in;
      stop_ff  <= stop_in;
      qidx_ff  <= qidx_in;
      stat_ff  <= stat_in;
      pages_ff <= pages_in;
      slot_ff  <= slot_in;
   end

   `ASSERT_CLK(a_err_fields_zero, rsp_tvalid && (stat_ff != prt_pkg::STAT_OK) |-> (pages_ff == '0) && (slot_ff == '0), "error response with nonzero page count or slot")
   `ASSERT_NEVER(a_one_request, req_tready && rsp_tvalid, "request taken while a response is pending")
   `ASSERT_CLK(a_skip_written, rd_en && (cmd_ff == prt_pkg::CMD_ALLOC) |-> addr_ff != nf_ff, "free slot search read the slot just written")
   `ASSERT_CLK(a_back_to_idle, rsp_tvalid && rsp_tready |=> req_tready, "not ready after response taken")

endmodule

FILE: tb/sv/page_region_tracker_checker.sv
// ---------------------------------------------------------------------------
// page_region_tracker_checker
// watches the request and response streams, keeps a copy of the region table
// and compares every response with the predicted one in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_region_tracker_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // base_address [31:0], length_bytes [62:32], zero [63]
   input  logic [prt_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd [0]
   input  logic [0:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status [1:0], page_count [13:2], slot_index [23:14]
   input  logic [prt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             fail_count,
   output int                             pending,
   output int                             checked
);

   localparam int AW = prt_pkg::ADDR_W;
   localparam int LW = prt_pkg::LEN_W;
   localparam int PS = prt_pkg::PAGE_SHIFT;
   localparam int CW = prt_pkg::COUNT_W;
   localparam int SW = prt_pkg::SLOT_W;
   localparam int TW = prt_pkg::STAT_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(32'hfff * prt_pkg::PAGE_BYTES);

   typedef struct packed {
      prt_pkg::status_type status;
      logic [CW-1:0]       pages;
      logic [SW-1:0]       slot;
   } reply_type;

   prt_pkg::entry_type regions [prt_pkg::ENTRIES];
   prt_pkg::idx_type   free_slot;
   logic               full;
   reply_type          replies_due [$];
   int                 fails;
   int                 seen;

   function automatic reply_type make_reply(prt_pkg::status_type s, logic [CW-1:0] p,
                                            logic [SW-1:0] i);
      reply_type r;
      r.status = s;
      r.pages  = p;
      r.slot   = i;
      return r;
   endfunction

   function automatic prt_pkg::idx_type next_slot(prt_pkg::idx_type i);
      return (i == prt_pkg::idx_type'(prt_pkg::ENTRIES - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic reply_type track_alloc(logic [AW-1:0] base, logic [LW-1:0] len);
      prt_pkg::idx_type written;
      prt_pkg::idx_type probe;
      if (base[PS-1:0] != '0) return make_reply(prt_pkg::STAT_INVALID, '0, '0);
      if (len[PS-1:0] != '0 || len > MAX_LEN)
         return make_reply(prt_pkg::STAT_INVALID, '0, '0);
      if (full) return make_reply(prt_pkg::STAT_EXHAUSTED, '0, '0);
      written = free_slot;
      regions[written] = {base[AW-1:PS], len[PS+CW-1:PS]};
      probe = next_slot(written);
      while (probe != written && regions[probe] != '0) probe = next_slot(probe);
      if (probe == written) full = 1'b1;
      else free_slot = probe;
      return make_reply(prt_pkg::STAT_OK, len[PS+CW-1:PS], SW'(written));
   endfunction

   function automatic reply_type track_remove(logic [AW-1:0] base);
      int            hit;
      logic [CW-1:0] pages;
      hit = -1;
      if (base[PS-1:0] != '0) return make_reply(prt_pkg::STAT_INVALID, '0, '0);
      for (int k = 0; k < prt_pkg::ENTRIES; k++) begin
         if (regions[k][AW-1:PS] == base[AW-1:PS]) begin
            hit = k;
            break;
         end
      end
      if (hit < 0) return make_reply(prt_pkg::STAT_NO_REGION, '0, '0);
      pages = regions[hit][CW-1:0];
      if (pages == '0) return make_reply(prt_pkg::STAT_NO_REGION, '0, '0);
      regions[hit] = '0;
      if (full) begin
         full = 1'b0;
         free_slot = prt_pkg::idx_type'(hit);
      end
      return make_reply(prt_pkg::STAT_OK, pages, SW'(hit));
   endfunction

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         for (int k = 0; k < prt_pkg::ENTRIES; k++) regions[k] = '0;
         free_slot = '0;
         full = 1'b0;
         replies_due.delete();
         fails = 0;
         seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = prt_pkg::status_type'(rsp_tdata[TW-1:0]);
            got.pages  = rsp_tdata[TW+CW-1:TW];
            got.slot   = rsp_tdata[TW+CW+SW-1:TW+CW];
            seen++;
            if (replies_due.size() == 0) begin
               if (fails < 10)
                  $display("%0t: response with nothing outstanding: st %0d pg %0d slot %0d",
                           $realtime, got.status, got.pages, got.slot);
               fails++;
            end else begin
               want = replies_due.pop_front();
               if (want.status != got.status || want.pages != got.pages ||
                   want.slot != got.slot) begin
                  if (fails < 10)
                     $display("%0t: expected st %0d pg %0d slot %0d, got st %0d pg %0d slot %0d",
                              $realtime, want.status, want.pages, want.slot,
                              got.status, got.pages, got.slot);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (prt_pkg::cmd_type'(req_tuser[0]) == prt_pkg::CMD_ALLOC)
               want = track_alloc(req_tdata[AW-1:0], req_tdata[AW+LW-1:AW]);
            else
               want = track_remove(req_tdata[AW-1:0]);
            replies_due.push_back(want);
         end
      end
      fail_count <= fails;
      pending    <= replies_due.size();
      checked    <= seen;
   end

   final begin
      if (replies_due.size() != 0)
         $display("checker: %0d responses still outstanding", replies_due.size());
   end

endmodule

FILE: tb/sv/tb_page_region_tracker_top.sv
// ---------------------------------------------------------------------------
// tb_page_region_tracker_top
// drives allocate and remove requests into the page region tracker: directed
// edge cases, then random mixes under three idle patterns and one long
// response stall; the checker beside the block compares every response
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_page_region_tracker_top;

   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int HOLD_CYCLES = 3000;
   localparam int POOL_SIZE   = 32;
   localparam int AW          = prt_pkg::ADDR_W;
   localparam int LW          = prt_pkg::LEN_W;
   localparam int PS          = prt_pkg::PAGE_SHIFT;
   localparam int PW          = prt_pkg::ADDR_W - prt_pkg::PAGE_SHIFT;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // base_address [31:0], length_bytes [62:32], zero [63]
   logic [prt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // cmd [0]
   logic [0:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // status [1:0], page_count [13:2], slot_index [23:14]
   logic [prt_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int   fail_count;
   int   pending;
   int   checked;

   int   send_idle = 0;
   int   recv_idle = 0;
   int   hold_trig = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   requests_sent = 0;
   int   cycles = 0;
   logic [PW-1:0] page_pool [POOL_SIZE];

   always #5 clock = ~clock;

   page_region_tracker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   page_region_tracker_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // response side: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_trig) begin
         hold_seen  <= hold_trig;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("tb_page_region_tracker_top: done, errors");
         $finish;
      end
   end

   task automatic push(prt_pkg::cmd_type c, logic [AW-1:0] base, logic [LW-1:0] len);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {1'b0, len, base};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   function automatic logic [AW-1:0] pick_base();
      int r;
      r = $urandom_range(99);
      if (r < 80) return {page_pool[$urandom_range(POOL_SIZE-1)], {PS{1'b0}}};
      if (r < 90) return $urandom & 32'hffff_f000;
      return $urandom;
   endfunction

   function automatic logic [LW-1:0] good_len();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 10) return LW'(32'hfff) << PS;
      return LW'($urandom_range(1, 4095)) << PS;
   endfunction

   function automatic logic [LW-1:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 80) return good_len();
      if (r < 85) return LW'(32'h1000) << PS;
      if (r < 92) return good_len() | LW'($urandom_range(1, 4095));
      return LW'($urandom);
   endfunction

   task automatic send_mix(int count, int alloc_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < alloc_pct) push(prt_pkg::CMD_ALLOC, pick_base(), pick_len());
         else push(prt_pkg::CMD_REMOVE, pick_base(), LW'($urandom));
      end
   endtask

   initial begin
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) page_pool[k] = PW'($urandom);

      send_idle = 12;
      recv_idle = 76;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // edge cases, starting from an empty table
      push(prt_pkg::CMD_REMOVE, 32'h0000_0000, '0);
      push(prt_pkg::CMD_ALLOC,  32'h0000_0001, 31'h0000_1000);
      push(prt_pkg::CMD_ALLOC,  32'hffff_f000, 31'h00ff_f000);
      push(prt_pkg::CMD_ALLOC,  32'h4000_0000, 31'h0100_0000);
      push(prt_pkg::CMD_ALLOC,  32'h4000_0000, 31'h0000_1001);
      push(prt_pkg::CMD_ALLOC,  32'h4000_0000, 31'h7fff_ffff);
      push(prt_pkg::CMD_ALLOC,  32'h1234_5000, 31'h0000_0000);
      push(prt_pkg::CMD_REMOVE, 32'h1234_5000, '0);
      push(prt_pkg::CMD_ALLOC,  32'h0000_0000, 31'h0000_1000);
      push(prt_pkg::CMD_REMOVE, 32'h0000_0000, '0);
      push(prt_pkg::CMD_REMOVE, 32'hffff_ffff, '0);
      push(prt_pkg::CMD_REMOVE, 32'hffff_f000, '0);
      push(prt_pkg::CMD_REMOVE, 32'hffff_f000, '0);
      push(prt_pkg::CMD_ALLOC,  32'h0000_0000, 31'h0000_0000);
      push(prt_pkg::CMD_REMOVE, 32'habcd_e000, 31'h7fff_ffff);
      push(prt_pkg::CMD_ALLOC,  32'h8000_0000, 31'h007f_f000);
      push(prt_pkg::CMD_ALLOC,  32'h0000_0800, 31'h0000_0000);
      push(prt_pkg::CMD_REMOVE, 32'h8000_0000, 31'h0000_0000);

      send_mix(60, 60);

      // long stall on the response side while requests keep coming
      hold_trig = hold_trig + 1;
      send_mix(12, 60);
      send_mix(80, 55);
      drain(8);

      send_idle = 76;
      recv_idle = 12;
      send_mix(160, 55);
      drain(8);

      send_idle = 0;
      recv_idle = 0;
      send_mix(140, 50);
      send_mix(110, 30);
      drain(20);

      $display("tb_page_region_tracker_top: %0d requests sent, %0d responses checked",
               requests_sent, checked);
      $display("tb_page_region_tracker_top: edge cases, random mixes, one long response stall");
      if (fail_count == 0) begin
         $display("tb_page_region_tracker_top: done, clean");
      end else begin
         $display("tb_page_region_tracker_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: page_region_tracker_top.f
+incdir+src
src/prt_pkg.sv
src/page_region_tracker_top.sv
tb/sv/page_region_tracker_checker.sv
tb/sv/tb_page_region_tracker_top.sv
